@@ rtl/core/brdt_pkg.sv @@
package brdt_pkg;

    localparam int BLK_W  = 16;
    localparam int ENT_W  = 16;
    localparam int ID_W   = 40;
    localparam int BKT_W  = 7;
    localparam int DIST_W = 29;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 48;
    localparam int SQR_W  = 64;
    localparam int MIB_SH = 8;
    localparam int GIB_SH = 10;
    localparam int BUCKETS = 1 << BKT_W;

    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_RD_ENTRY  = 2'd1;
    localparam logic [1:0] OP_RD_BUCKET = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [BLK_W-1:0] block_address;
        logic [ENT_W-1:0] read_index;
    } t_in;

    typedef struct packed {
        logic              is_new;
        logic [ENT_W-1:0]  entry_index;
        logic [DIST_W-1:0] distance_mib;
        logic [CNT_W-1:0]  count_out;
        logic [SUM_W-1:0]  sum_out;
        logic [SQR_W-1:0]  sqr_sum_out;
        logic [CNT_W-1:0]  bucket_count;
    } t_out;

    typedef struct packed {
        logic             accept;
        logic             clr_we;
        logic [BLK_W-1:0] clr_addr;
        logic             map_step;
        logic             exe_step;
        logic             upd_step;
        logic             rd_out;
    } t_cmd;

endpackage

@@ rtl/core/brdt_ctrl.sv @@
module brdt_ctrl
    import brdt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_op,
    output logic       o_busy,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MAP, S_EXE, S_UPD, S_READ} t_state;

    t_state           r_state, n_state;
    logic [BLK_W-1:0] r_clr, n_clr;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_op == OP_WRITE) ? S_MAP : S_READ;
                end
            end
            S_MAP:  n_state = S_EXE;
            S_EXE:  n_state = S_UPD;
            S_UPD:  n_state = S_IDLE;
            S_READ: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_cmd.accept   = (r_state == S_IDLE) && i_start;
    assign o_cmd.clr_we   = (r_state == S_CLEAR);
    assign o_cmd.clr_addr = r_clr;
    assign o_cmd.map_step = (r_state == S_MAP);
    assign o_cmd.exe_step = (r_state == S_EXE);
    assign o_cmd.upd_step = (r_state == S_UPD);
    assign o_cmd.rd_out   = (r_state == S_READ);

endmodule

@@ rtl/core/brdt_dp.sv @@
module brdt_dp
    import brdt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_in  i_in,
    output logic o_valid,
    output t_out o_res
);

    logic [ID_W-1:0]   r_lwid_mem [1 << BLK_W];
    logic [ENT_W-1:0]  r_map_mem  [1 << BLK_W];
    logic [CNT_W-1:0]  r_cnt_mem  [1 << ENT_W];
    logic [SUM_W-1:0]  r_sum_mem  [1 << ENT_W];
    logic [SQR_W-1:0]  r_sqr_mem  [1 << ENT_W];
    logic [CNT_W-1:0]  r_hist_mem [BUCKETS];
    logic [BUCKETS-1:0] r_hist_vld;

    t_in               r_in;
    logic [ID_W-1:0]   r_lwid_q, r_wc, n_wc;
    logic [ENT_W-1:0]  r_map_q, r_ent, n_ent, ent_new;
    logic [ENT_W:0]    r_next;
    logic [CNT_W-1:0]  r_cnt_q, r_hist_q;
    logic [SUM_W-1:0]  r_sum_q;
    logic [SQR_W-1:0]  r_sqr_q, r_sq;
    logic              r_ent_vq, r_hist_vq, r_new, n_new, r_valid;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic [BKT_W-1:0]  r_bkt, n_bkt;
    logic [ID_W-1:0]   diff;
    logic [CNT_W-1:0]  cnt, hist, n_cnt, n_hist;
    logic [SUM_W-1:0]  sum, n_sum;
    logic [SQR_W-1:0]  sqr, n_sqr;
    logic [SUM_W:0]    sum_add;
    logic [SQR_W:0]    sqr_add;
    logic [2*DIST_W-1:0] sq;
    t_out              r_res, n_res;

    always_comb begin
        n_new   = (r_lwid_q == '0);
        ent_new = r_next[ENT_W] ? '1 : r_next[ENT_W-1:0];
        n_ent   = n_new ? ent_new : r_map_q;
        diff    = r_wc - r_lwid_q;
        n_dist  = (|diff[ID_W-1:MIB_SH+DIST_W]) ? '1 : diff[MIB_SH+DIST_W-1:MIB_SH];
        n_wc    = (&r_wc) ? r_wc : r_wc + 1'b1;
        n_bkt   = (|r_dist[DIST_W-1:GIB_SH+BKT_W]) ? '1 : r_dist[GIB_SH+BKT_W-1:GIB_SH];
        sq      = r_dist * r_dist;
        cnt     = r_ent_vq ? r_cnt_q : '0;
        sum     = r_ent_vq ? r_sum_q : '0;
        sqr     = r_ent_vq ? r_sqr_q : '0;
        hist    = r_hist_vq ? r_hist_q : '0;
        n_cnt   = (&cnt) ? cnt : cnt + 1'b1;
        n_hist  = (&hist) ? hist : hist + 1'b1;
        sum_add = {1'b0, sum} + {{(SUM_W+1-DIST_W){1'b0}}, r_dist};
        n_sum   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        sqr_add = {1'b0, sqr} + {1'b0, r_sq};
        n_sqr   = sqr_add[SQR_W] ? '1 : sqr_add[SQR_W-1:0];

        n_res = '0;
        if (i_cmd.upd_step) begin
            n_res.is_new      = r_new;
            n_res.entry_index = r_ent;
            if (r_new) begin
                n_res.count_out   = cnt;
                n_res.sum_out     = sum;
                n_res.sqr_sum_out = sqr;
            end else begin
                n_res.distance_mib = r_dist;
                n_res.count_out    = n_cnt;
                n_res.sum_out      = n_sum;
                n_res.sqr_sum_out  = n_sqr;
                n_res.bucket_count = n_hist;
            end
        end else begin
            unique case (r_in.op)
                OP_RD_ENTRY: begin
                    n_res.entry_index = r_in.read_index;
                    n_res.count_out   = cnt;
                    n_res.sum_out     = sum;
                    n_res.sqr_sum_out = sqr;
                end
                OP_RD_BUCKET: n_res.bucket_count = hist;
                default: n_res = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we) begin
            r_lwid_mem[i_cmd.clr_addr] <= '0;
        end else if (i_cmd.map_step) begin
            r_lwid_mem[r_in.block_address] <= n_wc;
        end
        if (i_cmd.accept) begin
            r_lwid_q <= r_lwid_mem[i_in.block_address];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.map_step && n_new) begin
            r_map_mem[r_in.block_address] <= n_ent;
        end
        if (i_cmd.accept) begin
            r_map_q <= r_map_mem[i_in.block_address];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_step) begin
            r_cnt_mem[r_ent] <= n_res.count_out;
            r_sum_mem[r_ent] <= n_res.sum_out;
            r_sqr_mem[r_ent] <= n_res.sqr_sum_out;
        end
        if (i_cmd.accept) begin
            r_cnt_q  <= r_cnt_mem[i_in.read_index];
            r_sum_q  <= r_sum_mem[i_in.read_index];
            r_sqr_q  <= r_sqr_mem[i_in.read_index];
            r_ent_vq <= ({1'b0, i_in.read_index} < r_next);
        end else if (i_cmd.map_step) begin
            r_cnt_q  <= r_cnt_mem[n_ent];
            r_sum_q  <= r_sum_mem[n_ent];
            r_sqr_q  <= r_sqr_mem[n_ent];
            r_ent_vq <= ({1'b0, n_ent} < r_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_step && !r_new) begin
            r_hist_mem[r_bkt] <= n_hist;
        end
        if (i_cmd.accept) begin
            r_hist_q  <= r_hist_mem[i_in.read_index[BKT_W-1:0]];
            r_hist_vq <= r_hist_vld[i_in.read_index[BKT_W-1:0]]
                         && (i_in.read_index[ENT_W-1:BKT_W] == '0);
        end else if (i_cmd.exe_step) begin
            r_hist_q  <= r_hist_mem[n_bkt];
            r_hist_vq <= r_hist_vld[n_bkt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in;
        end
        if (i_cmd.map_step) begin
            r_new  <= n_new;
            r_ent  <= n_ent;
            r_dist <= n_dist;
        end
        if (i_cmd.exe_step) begin
            r_sq  <= {{(SQR_W-2*DIST_W){1'b0}}, sq};
            r_bkt <= n_bkt;
        end
        if (i_cmd.upd_step || i_cmd.rd_out) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc       <= '0;
            r_next     <= '0;
            r_hist_vld <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.upd_step || i_cmd.rd_out;
            if (i_cmd.map_step) begin
                r_wc <= n_wc;
                if (n_new && !r_next[ENT_W]) begin
                    r_next <= r_next + 1'b1;
                end
            end
            if (i_cmd.upd_step && !r_new) begin
                r_hist_vld[r_bkt] <= 1'b1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ rtl/core/block_rewrite_distance_tracker.sv @@
// A block write reads the block memories at acceptance, then passes the map state,
// where the entry memories are read, and the execute and update states; a read
// passes the read state. A new request is accepted only in idle, once the last is done.
// After reset, busy stays high while the write id memory is cleared.
// Results are strobed for one cycle on o_valid; the receiver cannot stall them.
module block_rewrite_distance_tracker
    import brdt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_in,
    output logic o_valid,
    output t_out o_res
);

    t_cmd cmd;

    brdt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_in.op),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    brdt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule
